FILE: design/ps2mh_pkg.sv
// ----------------------------------------------------------------------------
// ps2mh_pkg
// Shared constants and bit positions for the PS/2 mouse host link: protocol
// bytes, frame bit counts and the packing of the stream beats.
// ----------------------------------------------------------------------------
package ps2mh_pkg;

    // Stream beat widths (fields packed from bit 0 up, padded to whole bytes).
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // Output beat bit positions.
    localparam int OB_DRIVE_DATA   = 0;
    localparam int OB_DRIVE_ACTIVE = 1;
    localparam int OB_CLOCK_HOLD   = 2;
    localparam int OB_REPORT_VALID = 3;
    localparam int OB_BUTTONS_LO   = 4;
    localparam int OB_MOVE_X_LO    = 7;
    localparam int OB_MOVE_Y_LO    = 15;
    localparam int OB_WHEEL_LO     = 23;
    localparam int OB_STREAM_ON    = 31;
    localparam int OB_PARITY_ERROR = 32;

    // Input beat kinds carried on tuser.
    localparam logic OP_CLK_EDGE = 1'b0;
    localparam logic OP_SEND_REQ = 1'b1;

    // Command and reply bytes.
    localparam logic [7:0] CMD_ENABLE_REPORT = 8'hF4;
    localparam logic [7:0] RSP_ACK           = 8'hFA;
    localparam logic [7:0] RSP_RESEND        = 8'hFE;
    localparam logic [7:0] RSP_ERROR         = 8'hFC;
    localparam logic [7:0] ID_WHEEL          = 8'h03;
    localparam logic [7:0] ID_FIVE_BUTTON    = 8'h04;

    // Frame bit counts.
    localparam logic [3:0] CNT_IDLE   = 4'd0;
    localparam logic [3:0] CNT_LAST_D = 4'd8;
    localparam logic [3:0] CNT_PARITY = 4'd9;
    localparam logic [3:0] CNT_STOP   = 4'd10;
    localparam logic [3:0] CNT_TX_END = 4'd11;

    // Packet byte indexes.
    localparam logic [1:0] PKT_LAST_STD   = 2'd2;
    localparam logic [1:0] PKT_LAST_WHEEL = 2'd3;

    // One result of the link.
    typedef struct packed {
        logic       parity_error;
        logic       stream_on;
        logic [7:0] wheel;
        logic [7:0] move_y;
        logic [7:0] move_x;
        logic [2:0] buttons;
        logic       report_valid;
        logic       clock_hold;
        logic       drive_active;
        logic       drive_data;
    } t_result;

endpackage

FILE: design/ps2_mouse_host_link.sv
// A beat accepted on the slave side passes through the input register and then
// the result register before it is presented on the master side.
// Throughput: one beat per cycle unless the master side stalls; the per-edge
// step is a single pass of logic. Stalls on the master side back up through
// the input register only. Reset (i_rst_n low, synchronous) clears link state
// and both valid flags; the three-entry packet store is not cleared.
// ----------------------------------------------------------------------------
// ps2_mouse_host_link
// Host side of a PS/2 mouse link. Each input beat is a device clock falling
// edge with the sampled data level, or a request to send a command byte.
// ----------------------------------------------------------------------------
module ps2_mouse_host_link (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input beats.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] data_bit, [8:1] send_byte, [15:9] zero.
    input  logic [ps2mh_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] opcode.
    input  logic                                 s_axis_tuser,
    // Result beats.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] drive_data, [1] drive_active, [2] clock_hold, [3] report_valid,
    // [6:4] buttons, [14:7] move_x, [22:15] move_y, [30:23] wheel,
    // [31] stream_on, [32] parity_error, [39:33] zero.
    output logic [ps2mh_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import ps2mh_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic       r_in_op;
    logic       r_in_bit;
    logic [7:0] r_in_byte;

    // Link state.
    logic [3:0] r_count, n_count;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic       r_rx_active, n_rx_active;
    logic       r_tx_active, n_tx_active;
    logic       r_tx_pending, n_tx_pending;
    logic [7:0] r_tx_byte, n_tx_byte;
    logic [1:0] r_pkt_idx, n_pkt_idx;
    logic       r_stream, n_stream;
    logic       r_wheel, n_wheel;
    logic [7:0] r_pkt_store [3];
    logic       n_store_we;

    // Result register.
    logic       r_out_valid;
    t_result    r_out, n_out;

    logic       advance;
    logic       step;
    logic [1:0] last_idx;
    logic       parity_ok;
    logic       resend;
    logic [7:0] pkt_b0, pkt_b1, pkt_b2, pkt_b3;

    // Handshake: the result register frees when empty or taken.
    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_bit  <= s_axis_tdata[0];
            r_in_byte <= s_axis_tdata[8:1];
        end
    end

    // Packet bytes as seen at the parity edge: the byte in flight replaces
    // the stored entry at the current index.
    assign last_idx = r_wheel ? PKT_LAST_WHEEL : PKT_LAST_STD;
    assign pkt_b0   = (r_pkt_idx == 2'd0) ? r_rx_shift : r_pkt_store[0];
    assign pkt_b1   = (r_pkt_idx == 2'd1) ? r_rx_shift : r_pkt_store[1];
    assign pkt_b2   = (r_pkt_idx == 2'd2) ? r_rx_shift : r_pkt_store[2];
    assign pkt_b3   = (r_pkt_idx == 2'd3) ? r_rx_shift : 8'd0;
    assign parity_ok = ^{r_rx_shift, r_in_bit};

    // One step of the link for the item in the input register.
    always_comb begin
        n_count      = r_count;
        n_rx_shift   = r_rx_shift;
        n_rx_active  = r_rx_active;
        n_tx_active  = r_tx_active;
        n_tx_pending = r_tx_pending;
        n_tx_byte    = r_tx_byte;
        n_pkt_idx    = r_pkt_idx;
        n_stream     = r_stream;
        n_wheel      = r_wheel;
        n_store_we   = 1'b0;
        resend       = 1'b0;
        n_out        = '0;

        if (r_in_op == OP_SEND_REQ) begin
            // A request waits only when a frame needs nothing but its stop bit.
            n_tx_byte = r_in_byte;
            if (!r_tx_active && r_rx_active && r_count == CNT_STOP) begin
                n_tx_pending = 1'b1;
            end else begin
                n_rx_active      = 1'b0;
                n_tx_active      = 1'b1;
                n_tx_pending     = 1'b0;
                n_count          = CNT_IDLE;
                n_out.clock_hold = 1'b1;
            end
        end else if (r_tx_active) begin
            // Transmit: data bits, odd parity, stop, then release.
            n_count = r_count + 4'd1;
            if (n_count >= 4'd1 && n_count <= CNT_LAST_D) begin
                n_out.drive_data   = r_tx_byte[3'(n_count - 4'd1)];
                n_out.drive_active = 1'b1;
            end else if (n_count == CNT_PARITY) begin
                n_out.drive_data   = ~(^r_tx_byte);
                n_out.drive_active = 1'b1;
            end else if (n_count == CNT_STOP) begin
                n_out.drive_data   = 1'b1;
                n_out.drive_active = 1'b1;
            end else begin
                n_tx_active = 1'b0;
                n_count     = CNT_IDLE;
            end
        end else begin
            // Receive.
            if (r_count == CNT_IDLE) begin
                n_rx_active = 1'b1;
                n_rx_shift  = 8'd0;
                n_count     = 4'd1;
            end else if (r_count <= CNT_LAST_D) begin
                n_rx_shift = r_rx_shift | (8'(r_in_bit) << 3'(r_count - 4'd1));
                n_count    = r_count + 4'd1;
            end else if (r_count == CNT_PARITY) begin
                n_out.parity_error = !parity_ok;
                if (parity_ok && r_stream && r_pkt_idx == last_idx) begin
                    n_out.report_valid = 1'b1;
                    n_out.buttons      = pkt_b0[2:0];
                    n_out.move_x       = pkt_b1;
                    n_out.move_y       = 8'd0 - pkt_b2;
                    n_out.wheel        = r_wheel ? (8'd0 - pkt_b3) : 8'd0;
                end
                n_count = CNT_STOP;
            end else begin
                // Stop edge: store a packet byte or act on a command reply, then start any resend or waiting send.
                n_rx_active = 1'b0;
                n_count     = CNT_IDLE;
                if (r_stream) begin
                    n_store_we = (r_pkt_idx != 2'd3);
                    n_pkt_idx  = (r_pkt_idx >= last_idx) ? 2'd0 : r_pkt_idx + 2'd1;
                end else begin
                    case (r_rx_shift)
                        RSP_ACK: begin
                            if (r_tx_byte == CMD_ENABLE_REPORT) begin
                                n_stream  = 1'b1;
                                n_pkt_idx = 2'd0;
                            end
                        end
                        RSP_RESEND, RSP_ERROR: begin
                            resend = 1'b1;
                        end
                        ID_WHEEL, ID_FIVE_BUTTON: begin
                            n_wheel = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                if (resend || r_tx_pending) begin
                    n_rx_active      = 1'b0;
                    n_tx_active      = 1'b1;
                    n_tx_pending     = 1'b0;
                    n_count          = CNT_IDLE;
                    n_out.clock_hold = 1'b1;
                end
            end
        end
        n_out.stream_on = n_stream;
    end

    // Link state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= CNT_IDLE;
            r_rx_shift   <= 8'd0;
            r_rx_active  <= 1'b0;
            r_tx_active  <= 1'b0;
            r_tx_pending <= 1'b0;
            r_tx_byte    <= 8'd0;
            r_pkt_idx    <= 2'd0;
            r_stream     <= 1'b0;
            r_wheel      <= 1'b0;
        end else if (step) begin
            r_count      <= n_count;
            r_rx_shift   <= n_rx_shift;
            r_rx_active  <= n_rx_active;
            r_tx_active  <= n_tx_active;
            r_tx_pending <= n_tx_pending;
            r_tx_byte    <= n_tx_byte;
            r_pkt_idx    <= n_pkt_idx;
            r_stream     <= n_stream;
            r_wheel      <= n_wheel;
        end
    end

    // Packet store, written at the stop edge of a stream byte.
    always_ff @(posedge i_clk) begin
        if (step && n_store_we) begin
            r_pkt_store[r_pkt_idx] <= r_rx_shift;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

endmodule

FILE: design/ps2mh_checker.sv
// ----------------------------------------------------------------------------
// ps2mh_checker
// Port-level checks of the PS/2 mouse host link result stream, bound to the
// top level.
// ----------------------------------------------------------------------------
module ps2mh_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ps2mh_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ps2mh_pkg::*;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Reports come only in stream mode and only with good parity.
    a_report_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OB_REPORT_VALID] |->
            m_axis_tdata[OB_STREAM_ON] && !m_axis_tdata[OB_PARITY_ERROR])
        else $error("report outside stream mode or with bad parity");

    // The data level is low whenever the host does not drive the line.
    a_drive_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OB_DRIVE_ACTIVE] |-> !m_axis_tdata[OB_DRIVE_DATA])
        else $error("data driven high while line released");

    // Holding the clock starts a send; it never coincides with driving or a report.
    a_hold_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OB_CLOCK_HOLD] |->
            !m_axis_tdata[OB_DRIVE_ACTIVE] && !m_axis_tdata[OB_REPORT_VALID])
        else $error("clock hold together with drive or report");

endmodule

bind ps2_mouse_host_link ps2mh_checker u_ps2mh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/ps2_mouse_host_link_test.sv
// ----------------------------------------------------------------------------
// ps2_mouse_host_link_test
// Self-checking regression for the PS/2 mouse host link. A behavioral copy of
// the link runs beside the block and predicts one result beat for every
// accepted input beat. The stimulus covers command replies, resends, send
// collisions, stream packets and random traffic under several idling and
// backpressure patterns.
// ----------------------------------------------------------------------------
module ps2_mouse_host_link_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ps2mh_pkg::*;

    // Power-on reply of the mouse; the link ignores it.
    localparam logic [7:0] RSP_SELF_TEST_OK = 8'hAA;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_PRINTED  = 40;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tuser = OP_CLK_EDGE;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    ps2_mouse_host_link uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted link state.
    logic [3:0] bit_cnt   = CNT_IDLE;
    logic [7:0] rx_sr     = '0;
    logic       rx_busy   = 1'b0;
    logic       rx_par_ok = 1'b0;
    logic       tx_busy   = 1'b0;
    logic       tx_defer  = 1'b0;
    logic [7:0] tx_cmd    = '0;
    logic [1:0] pkt_idx   = '0;
    logic [7:0] pkt_buf [3] = '{8'h00, 8'h00, 8'h00};
    logic       streaming = 1'b0;
    logic       wheel_on  = 1'b0;

    t_result     expected_link_outs [$];
    int unsigned beats_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned reports_seen    = 0;
    int unsigned err_count       = 0;
    int unsigned cycle_count     = 0;
    int unsigned src_idle_pct    = 0;
    int unsigned sink_stall_pct  = 0;
    int unsigned hold_left       = 0;
    logic        wheel_plan      = 1'b0;
    event        hold_kick;

    // Host pulls the clock low and takes the data line for a new send.
    function automatic void start_send();
        rx_busy  = 1'b0;
        tx_busy  = 1'b1;
        tx_defer = 1'b0;
        bit_cnt  = CNT_IDLE;
    endfunction

    // Packet byte i as seen at the parity edge of the last byte.
    function automatic logic [7:0] packet_byte_at(int unsigned i);
        if (i == pkt_idx) return rx_sr;
        if (i < 3) return pkt_buf[i];
        return 8'h00;
    endfunction

    // Advances the predicted link by one beat and returns its result.
    function automatic t_result predict_link_step(logic op, logic din, logic [7:0] cmd);
        t_result    r;
        logic [1:0] last_idx;
        logic       resend;
        r        = '0;
        resend   = 1'b0;
        last_idx = wheel_on ? PKT_LAST_WHEEL : PKT_LAST_STD;
        if (op == OP_SEND_REQ) begin
            tx_cmd = cmd;
            // A frame waiting only for its stop bit defers the send.
            if (!tx_busy && rx_busy && bit_cnt == CNT_STOP) begin
                tx_defer = 1'b1;
            end else begin
                start_send();
                r.clock_hold = 1'b1;
            end
        end else if (tx_busy) begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd1 && bit_cnt <= CNT_LAST_D) begin
                r.drive_data   = tx_cmd[bit_cnt - 4'd1];
                r.drive_active = 1'b1;
            end else if (bit_cnt == CNT_PARITY) begin
                r.drive_data   = ~^tx_cmd;
                r.drive_active = 1'b1;
            end else if (bit_cnt == CNT_STOP) begin
                r.drive_data   = 1'b1;
                r.drive_active = 1'b1;
            end else begin
                tx_busy = 1'b0;
                bit_cnt = CNT_IDLE;
            end
        end else if (bit_cnt == CNT_IDLE) begin
            rx_busy = 1'b1;
            rx_sr   = 8'h00;
            bit_cnt = 4'd1;
        end else if (bit_cnt <= CNT_LAST_D) begin
            rx_sr[bit_cnt - 4'd1] = rx_sr[bit_cnt - 4'd1] | din;
            bit_cnt = bit_cnt + 4'd1;
        end else if (bit_cnt == CNT_PARITY) begin
            rx_par_ok      = ^rx_sr ^ din;
            r.parity_error = !rx_par_ok;
            if (rx_par_ok && streaming && pkt_idx == last_idx) begin
                r.report_valid = 1'b1;
                r.buttons      = packet_byte_at(0) & 8'h07;
                r.move_x       = packet_byte_at(1);
                r.move_y       = 8'd0 - packet_byte_at(2);
                r.wheel        = wheel_on ? 8'd0 - packet_byte_at(3) : 8'd0;
            end
            bit_cnt = CNT_STOP;
        end else begin
            // Stop edge: the byte is complete.
            rx_busy = 1'b0;
            bit_cnt = CNT_IDLE;
            if (streaming) begin
                if (pkt_idx < 2'd3) pkt_buf[pkt_idx] = rx_sr;
                pkt_idx = (pkt_idx >= last_idx) ? 2'd0 : pkt_idx + 2'd1;
            end else begin
                case (rx_sr)
                    RSP_ACK: begin
                        if (tx_cmd == CMD_ENABLE_REPORT) begin
                            streaming = 1'b1;
                            pkt_idx   = 2'd0;
                        end
                    end
                    RSP_RESEND, RSP_ERROR: begin
                        resend = 1'b1;
                    end
                    ID_WHEEL, ID_FIVE_BUTTON: begin
                        wheel_on = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (resend || tx_defer) begin
                start_send();
                r.clock_hold = 1'b1;
            end
        end
        r.stream_on = streaming;
        return r;
    endfunction

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("MISMATCH at result %0d: %s", results_checked, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task automatic check_result(input t_result got, input t_result want);
        compare_field("drive_data",   got.drive_data,   want.drive_data);
        compare_field("drive_active", got.drive_active, want.drive_active);
        compare_field("clock_hold",   got.clock_hold,   want.clock_hold);
        compare_field("report_valid", got.report_valid, want.report_valid);
        compare_field("buttons",      got.buttons,      want.buttons);
        compare_field("move_x",       got.move_x,       want.move_x);
        compare_field("move_y",       got.move_y,       want.move_y);
        compare_field("wheel",        got.wheel,        want.wheel);
        compare_field("stream_on",    got.stream_on,    want.stream_on);
        compare_field("parity_error", got.parity_error, want.parity_error);
    endtask

    // Checks result beats and predicts each accepted input beat.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (expected_link_outs.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                    check_result(got, expected_link_outs.pop_front());
                if (got.report_valid === 1'b1) reports_seen++;
                results_checked++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_link_outs.push_back(predict_link_step(
                    s_axis_tuser, s_axis_tdata[0], s_axis_tdata[8:1]));
                beats_accepted++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("ps2_mouse_host_link regression: fail");
            $finish;
        end
    end

    // Long receiver hold-off, counted here once kicked.
    always begin
        @(hold_kick);
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        while (hold_left != 0) begin
            @(posedge i_clk);
            hold_left--;
        end
    end

    // Receiver ready with random stalls.
    always @(negedge i_clk) begin
        if (hold_left != 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Offers one beat and returns at the falling edge after it is taken.
    task automatic send_beat(input logic op, input logic din, input logic [7:0] cmd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {7'd0, cmd, din};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic clock_edge(input logic level);
        send_beat(OP_CLK_EDGE, level, 8'($urandom));
    endtask

    task automatic send_request(input logic [7:0] cmd);
        send_beat(OP_SEND_REQ, 1'($urandom), cmd);
    endtask

    // First n_edges edges of a device frame: start, data LSB first, parity, stop.
    task automatic device_frame(input logic [7:0] value, input logic good_parity,
                                input int unsigned n_edges);
        logic [10:0] levels;
        levels = {1'b1, good_parity ? ~^value : ^value, value, 1'($urandom)};
        for (int unsigned i = 0; i < n_edges; i++) clock_edge(levels[i]);
    endtask

    // Clocks edges until no send or receive frame is under way.
    task automatic settle_link();
        while (tx_busy || tx_defer || bit_cnt != CNT_IDLE) clock_edge(1'($urandom));
    endtask

    task automatic host_command(input logic [7:0] cmd);
        send_request(cmd);
        settle_link();
    endtask

    task automatic send_packet(input logic [7:0] b0, b1, b2, b3,
                               input int unsigned bad_at);
        logic [7:0]  bytes_out [4];
        int unsigned n;
        bytes_out = '{b0, b1, b2, b3};
        n = wheel_on ? 4 : 3;
        for (int unsigned i = 0; i < n; i++) device_frame(bytes_out[i], i != bad_at, 11);
    endtask

    task automatic wait_drained();
        while (expected_link_outs.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        wait_drained();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Any reply byte except the device IDs, which would fix the packet size.
    function automatic logic [7:0] pick_reply();
        logic [7:0] v;
        case ($urandom_range(4))
            0: v = RSP_SELF_TEST_OK;
            1: v = RSP_ACK;
            2: v = RSP_RESEND;
            3: v = RSP_ERROR;
            default: begin
                do v = 8'($urandom); while (v == ID_WHEEL || v == ID_FIVE_BUTTON);
            end
        endcase
        return v;
    endfunction

    // Any command except enable reporting, so stream mode stays off.
    function automatic logic [7:0] pick_command();
        logic [7:0] v;
        do v = 8'($urandom); while (v == CMD_ENABLE_REPORT);
        return v;
    endfunction

    // Replies handled before stream mode, including parity errors.
    task automatic test_command_replies();
        device_frame(RSP_SELF_TEST_OK, 1'b1, 11);
        device_frame(RSP_ACK, 1'b1, 11);
        device_frame(RSP_RESEND, 1'b1, 11);
        settle_link();
        host_command(8'hFF);
        host_command(8'h00);
        device_frame(RSP_ERROR, 1'b0, 11);
        settle_link();
        device_frame(8'h5A, 1'b0, 11);
    endtask

    // Requests that land inside a receive or a send.
    task automatic test_send_collisions();
        // Receive abandoned after the data bits started.
        device_frame(8'h3C, 1'b1, 5);
        send_request(8'hA5);
        settle_link();
        // Receive abandoned at its parity edge.
        device_frame(8'h81, 1'b1, 9);
        send_request(8'h7E);
        settle_link();
        // Only the stop bit left: the send waits for it.
        device_frame(8'hC3, 1'b1, 10);
        send_request(8'h96);
        settle_link();
        // A second request restarts a send in progress.
        send_request(8'h12);
        repeat (4) clock_edge(1'($urandom));
        host_command(8'hED);
    endtask

    task automatic run_command_traffic(input int unsigned n_beats);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = beats_accepted + n_beats;
        while (beats_accepted < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                device_frame(pick_reply(), $urandom_range(99) < 85, 11);
            end else if (pick < 70) begin
                send_request(pick_command());
            end else if (pick < 88) begin
                device_frame(pick_reply(), 1'($urandom), $urandom_range(1, 10));
                send_request(pick_command());
            end else begin
                send_request(pick_command());
                repeat ($urandom_range(0, 10)) clock_edge(1'($urandom));
                send_request(pick_command());
            end
            settle_link();
        end
    endtask

    // Optional device ID, then enable reporting and its acknowledge.
    task automatic test_stream_enable();
        if (wheel_plan)
            device_frame($urandom_range(1) ? ID_WHEEL : ID_FIVE_BUTTON, 1'b1, 11);
        host_command(CMD_ENABLE_REPORT);
        device_frame(RSP_ACK, 1'b1, 11);
    endtask

    task automatic test_packet_extremes();
        send_packet(8'hFF, 8'h80, 8'h80, 8'h80, 4);
        send_packet(8'h00, 8'h7F, 8'h7F, 8'h7F, 4);
        send_packet(8'hF8, 8'hFF, 8'hFF, 8'hFF, 4);
        send_packet(8'h07, 8'h01, 8'h00, 8'h01, 4);
        // Bad parity on the last byte suppresses the report.
        send_packet(8'h09, 8'h10, 8'hF0, 8'h22, wheel_on ? 3 : 2);
        // Bad parity on a middle byte still advances the packet.
        send_packet(8'h0A, 8'h20, 8'hE0, 8'h33, 1);
        // A request in stream mode sends normally.
        host_command(RSP_RESEND);
    endtask

    // Receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        set_idling(0, 0);
        -> hold_kick;
        repeat (3) send_packet(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 4);
        wait_drained();
    endtask

    task automatic run_stream_traffic(input int unsigned n_beats);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = beats_accepted + n_beats;
        while (beats_accepted < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_packet(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            ($urandom_range(9) == 0) ? $urandom_range(3) : 4);
            end else if (pick < 88) begin
                device_frame(8'($urandom), 1'($urandom), $urandom_range(1, 10));
                send_request(8'($urandom));
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 12)) clock_edge(1'($urandom));
            end else begin
                send_request(8'($urandom));
                repeat ($urandom_range(0, 10)) clock_edge(1'($urandom));
                send_request(8'($urandom));
            end
            settle_link();
        end
    endtask

    initial begin
        wheel_plan = 1'($urandom_range(1));
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_command_replies();
        test_send_collisions();
        run_command_traffic(80);
        set_idling(35, 35);
        run_command_traffic(50);
        set_idling(0, 0);
        test_stream_enable();
        test_packet_extremes();
        test_backpressure();
        run_stream_traffic(140);
        set_idling(68, 0);
        run_stream_traffic(140);
        set_idling(0, 68);
        run_stream_traffic(140);
        set_idling(35, 35);
        run_stream_traffic(140);

        s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_link_outs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_link_outs.size()));

        $display("Ran %0d link beats in %0d cycles; checked %0d results, %0d of them reports.",
                 beats_accepted, cycle_count, results_checked, reports_seen);
        $display("Packets were %0s-byte; %0d mismatches seen.",
                 wheel_on ? "four" : "three", err_count);
        if (err_count == 0)
            $display("ps2_mouse_host_link regression: pass");
        else
            $display("ps2_mouse_host_link regression: fail");
        $finish;
    end

endmodule

FILE: ps2_mouse_host_link.f
design/ps2mh_pkg.sv
design/ps2_mouse_host_link.sv
design/ps2mh_checker.sv
dv/ps2_mouse_host_link_test.sv
